[src/nearest_neighbor_scale_pixel_pack_unit_defines.svh]
// assertion macros shared by the checker
`ifndef NEAREST_NEIGHBOR_SCALE_PIXEL_PACK_UNIT_DEFINES_SVH
`define NEAREST_NEIGHBOR_SCALE_PIXEL_PACK_UNIT_DEFINES_SVH

// clocked assertion, off while reset is active
`define NNSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, checked during reset too
`define NNSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/nnsp_pkg.sv]
package nnsp_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd4;

  // request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // pixel formats
  localparam logic [1:0] FMT_BGRA = 2'd0;
  localparam logic [1:0] FMT_RGBA = 2'd1;

  // status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FORMAT = 2'd1;
  localparam logic [1:0] STATUS_RANGE  = 2'd2;

  localparam logic [7:0] ALPHA_BYTE = 8'hFF;
  localparam int FRAC_BITS = 16;
  localparam int DIVISOR_W = 13;

  // frame memory control
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

[src/nnsp_div.sv]
module nnsp_div #(
  parameter int DVW = 28
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [DVW-1:0]                 dividend_i,
  input  logic [nnsp_pkg::DIVISOR_W-1:0] divisor_i,
  output logic                           done_o,
  output logic [DVW-1:0]                 quotient_o
);
  import nnsp_pkg::*;

  localparam int CNTW = $clog2(DVW + 1);

  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dsr_q;
  logic [DVW-1:0]       quo_q, quo_d;
  logic [CNTW-1:0]      cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [DIVISOR_W:0]   trial;

  // one restoring step per cycle
  always_comb begin
    trial = {rem_q, quo_q[DVW-1]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = DIVISOR_W'(trial - {1'b0, dsr_q});
      quo_d = {quo_q[DVW-2:0], 1'b1};
    end else begin
      rem_d = trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DVW-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNTW'(DVW);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[src/nnsp_frame_mem.sv]
module nnsp_frame_mem #(
  parameter int DEPTH = 1048576,
  parameter int AW    = 20
) (
  input  logic               clk_i,
  input  nnsp_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]      addr_i,
  input  logic [23:0]        wr_data_i,
  output logic [23:0]        rd_data_o
);
  import nnsp_pkg::*;

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_data_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/nearest_neighbor_scale_pixel_pack_unit.sv]
// channel   | direction | handshake             | payload
// request   | in        | start_i, busy_o       | req_type, pos_x, pos_y, red, green, blue
// config    | in        | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
// result    | out       | done_o strobe         | pixel_word_o, status_o
//
// one request per cycle while busy_o is low; a fetch result passes the stage registers,
// the memory read register and the result register before done_o.
// a config write starts the scale-factor setup: two serial divisions of one bit a
// cycle in the shared divider, with busy_o high meanwhile.
// reset clears control and sets config to defaults; no memory clearing pass.
// loads and fetches reach the frame memory port at the same stage, in request order.
// the receiver cannot stall.
module nearest_neighbor_scale_pixel_pack_unit #(
  parameter int MAX_SRC_WIDTH  = 1024,
  parameter int MAX_SRC_HEIGHT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            req_type_i,
  input  logic [11:0]                     pos_x_i,
  input  logic [11:0]                     pos_y_i,
  input  logic [7:0]                      red_i,
  input  logic [7:0]                      green_i,
  input  logic [7:0]                      blue_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nnsp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nnsp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            done_o,
  output logic [31:0]                     pixel_word_o,
  output logic [1:0]                      status_o
);
  import nnsp_pkg::*;

  localparam int SWW   = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHW   = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int CW    = $clog2(MAX_SRC_WIDTH);
  localparam int RWD   = $clog2(MAX_SRC_HEIGHT);
  localparam int STW   = SWW + FRAC_BITS;
  localparam int NW    = 12 + SHW;
  localparam int RCW   = NW + 1;
  localparam int DVW   = (STW > RCW) ? STW : RCW;
  localparam int CPW   = 12 + STW;
  localparam int CRW   = CPW - FRAC_BITS;
  localparam int PW    = NW + RCW;
  localparam int MW    = NW + DIVISOR_W;
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    SU_IDLE,
    SU_LAUNCH,
    SU_STEP,
    SU_RECIP
  } setup_e;

  // configuration registers
  logic [10:0] src_width_q, src_height_q;
  logic [12:0] dst_width_q, dst_height_q;
  logic [1:0]  pixel_format_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q    <= 11'd1;
      src_height_q   <= 11'd1;
      dst_width_q    <= 13'd1;
      dst_height_q   <= 13'd1;
      pixel_format_q <= FMT_BGRA;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_SRC_WIDTH:    src_width_q    <= cfg_data_i[10:0];
        REG_SRC_HEIGHT:   src_height_q   <= cfg_data_i[10:0];
        REG_DST_WIDTH:    dst_width_q    <= cfg_data_i;
        REG_DST_HEIGHT:   dst_height_q   <= cfg_data_i;
        REG_PIXEL_FORMAT: pixel_format_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // saturated source size
  logic [12:0] sw_full, sh_full;
  assign sw_full = (13'(src_width_q) > 13'(MAX_SRC_WIDTH)) ? 13'(MAX_SRC_WIDTH)
                                                           : 13'(src_width_q);
  assign sh_full = (13'(src_height_q) > 13'(MAX_SRC_HEIGHT)) ? 13'(MAX_SRC_HEIGHT)
                                                             : 13'(src_height_q);

  // scale factor setup: column step, then row reciprocal
  setup_e               state_q;
  logic                 div_start_q;
  logic                 div_sel_q;
  logic [STW-1:0]       step_q;
  logic [RCW-1:0]       recip_q;
  logic                 div_done;
  logic [DVW-1:0]       div_quo;
  logic [DVW-1:0]       div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;

  assign div_dividend = div_sel_q ? (DVW'(1) << NW) : (DVW'(SWW'(sw_full)) << FRAC_BITS);
  assign div_divisor  = div_sel_q ? dst_height_q : dst_width_q;

  // a done left over from an aborted division is ignored while the new one starts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SU_IDLE;
      div_start_q <= 1'b0;
      div_sel_q   <= 1'b0;
      step_q      <= STW'(1) << FRAC_BITS;
      recip_q     <= RCW'(1) << NW;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_we) begin
        state_q <= SU_LAUNCH;
      end else begin
        case (state_q)
          SU_LAUNCH: begin
            div_start_q <= 1'b1;
            div_sel_q   <= 1'b0;
            state_q     <= SU_STEP;
          end
          SU_STEP: begin
            if (div_done && !div_start_q) begin
              step_q      <= STW'(div_quo);
              div_start_q <= 1'b1;
              div_sel_q   <= 1'b1;
              state_q     <= SU_RECIP;
            end
          end
          SU_RECIP: begin
            if (div_done && !div_start_q) begin
              recip_q <= RCW'(div_quo);
              state_q <= SU_IDLE;
            end
          end
          default: state_q <= SU_IDLE;
        endcase
      end
    end
  end

  nnsp_div #(.DVW(DVW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign busy_o = (state_q != SU_IDLE);

  logic accept;
  assign accept = start_i & ~busy_o;

  // stage 1: request register
  logic        v1_q, type1_q;
  logic [11:0] x1_q, y1_q;
  logic [23:0] rgb1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type1_q <= req_type_i;
      x1_q    <= pos_x_i;
      y1_q    <= pos_y_i;
      rgb1_q  <= {red_i, green_i, blue_i};
    end
  end

  // classify request, start both scale products
  logic           load_ok1;
  logic [1:0]     st1;
  logic [CPW-1:0] colp1;
  logic [NW-1:0]  n1;

  always_comb begin
    load_ok1 = ({1'b0, x1_q} < sw_full) && ({1'b0, y1_q} < sh_full);
    if (pixel_format_q > FMT_RGBA) begin
      st1 = STATUS_FORMAT;
    end else if (({1'b0, x1_q} >= dst_width_q) || ({1'b0, y1_q} >= dst_height_q) ||
                 (sw_full == 13'd0) || (sh_full == 13'd0)) begin
      st1 = STATUS_RANGE;
    end else begin
      st1 = STATUS_OK;
    end
    colp1 = CPW'(x1_q) * CPW'(step_q);
    n1    = NW'(y1_q) * NW'(SHW'(sh_full));
  end

  // stage 2
  logic           v2_q, type2_q, we2_q;
  logic [1:0]     st2_q;
  logic [CPW-1:0] colp2_q;
  logic [NW-1:0]  n2_q;
  logic [CW-1:0]  xl2_q;
  logic [RWD-1:0] yl2_q;
  logic [23:0]    rgb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    type2_q <= type1_q;
    we2_q   <= (type1_q == REQ_LOAD) && load_ok1;
    st2_q   <= st1;
    colp2_q <= colp1;
    n2_q    <= n1;
    xl2_q   <= CW'(x1_q);
    yl2_q   <= RWD'(y1_q);
    rgb2_q  <= rgb1_q;
  end

  // source column, row estimate by reciprocal
  logic [CRW-1:0] col_raw2, col_lim2;
  logic [CW-1:0]  col2;
  logic [PW-1:0]  prod2;

  always_comb begin
    col_raw2 = colp2_q[CPW-1:FRAC_BITS];
    col_lim2 = CRW'(sw_full) - 1'b1;
    col2     = (col_raw2 > col_lim2) ? CW'(col_lim2) : CW'(col_raw2);
    prod2    = PW'(n2_q) * PW'(recip_q);
  end

  // stage 3
  logic           v3_q, type3_q, we3_q;
  logic [1:0]     st3_q;
  logic [NW-1:0]  n3_q;
  logic [PW-1:0]  prod3_q;
  logic [CW-1:0]  col3_q, xl3_q;
  logic [RWD-1:0] yl3_q;
  logic [23:0]    rgb3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    type3_q <= type2_q;
    we3_q   <= we2_q;
    st3_q   <= st2_q;
    n3_q    <= n2_q;
    prod3_q <= prod2;
    col3_q  <= col2;
    xl3_q   <= xl2_q;
    yl3_q   <= yl2_q;
    rgb3_q  <= rgb2_q;
  end

  // row correction: estimate may be one low
  logic [NW-1:0]  q0_3, q3, row_lim3;
  logic [MW-1:0]  m3, rem3;
  logic [RWD-1:0] row3;

  always_comb begin
    q0_3     = NW'(prod3_q >> NW);
    m3       = MW'(q0_3) * MW'(dst_height_q);
    rem3     = MW'(n3_q) - m3;
    q3       = (rem3 >= MW'(dst_height_q)) ? (q0_3 + 1'b1) : q0_3;
    row_lim3 = NW'(sh_full) - 1'b1;
    row3     = (q3 > row_lim3) ? RWD'(row_lim3) : RWD'(q3);
  end

  // stage 4: frame memory access
  logic           v4_q, fetch4_q, we4_q, re4_q;
  logic [1:0]     st4_q;
  logic [RWD-1:0] row4_q;
  logic [CW-1:0]  col4_q;
  logic [23:0]    rgb4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fetch4_q <= (type3_q == REQ_FETCH);
    we4_q    <= we3_q;
    re4_q    <= (type3_q == REQ_FETCH) && (st3_q == STATUS_OK);
    st4_q    <= st3_q;
    row4_q   <= (type3_q == REQ_FETCH) ? row3 : yl3_q;
    col4_q   <= (type3_q == REQ_FETCH) ? col3_q : xl3_q;
    rgb4_q   <= rgb3_q;
  end

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [23:0]   mem_rd_data;

  assign mem_ctl.wr_en = v4_q & we4_q;
  assign mem_ctl.rd_en = v4_q & re4_q;
  assign mem_addr      = AW'(row4_q) * AW'(MAX_SRC_WIDTH) + AW'(col4_q);

  nnsp_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .addr_i    (mem_addr),
    .wr_data_i (rgb4_q),
    .rd_data_o (mem_rd_data)
  );

  // stage 5: pack
  logic       v5_q;
  logic [1:0] st5_q;
  logic [31:0] word5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q & fetch4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st5_q <= st4_q;
  end

  always_comb begin
    if (st5_q != STATUS_OK) begin
      word5 = 32'd0;
    end else if (pixel_format_q == FMT_BGRA) begin
      word5 = {ALPHA_BYTE, mem_rd_data[23:16], mem_rd_data[15:8], mem_rd_data[7:0]};
    end else begin
      word5 = {ALPHA_BYTE, mem_rd_data[7:0], mem_rd_data[15:8], mem_rd_data[23:16]};
    end
  end

  // result register
  logic        done_q;
  logic [31:0] word_q;
  logic [1:0]  status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word5;
    status_q <= st5_q;
  end

  assign done_o       = done_q;
  assign pixel_word_o = word_q;
  assign status_o     = status_q;

endmodule

[src/nnsp_checker.sv]
`include "nearest_neighbor_scale_pixel_pack_unit_defines.svh"

module nnsp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            busy_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic                            done_o,
  input logic [31:0]                     pixel_word_o,
  input logic [1:0]                      status_o
);
  import nnsp_pkg::*;

  // results carry only known status codes
  `NNSP_ASSERT(a_status_code, done_o |-> (status_o == STATUS_OK || status_o == STATUS_FORMAT || status_o == STATUS_RANGE), "unknown status code")

  // an error result carries a zero word
  `NNSP_ASSERT(a_error_zero, (done_o && status_o != STATUS_OK) |-> (pixel_word_o == 32'd0), "error result with nonzero word")

  // a good result carries the alpha byte
  `NNSP_ASSERT(a_alpha, (done_o && status_o == STATUS_OK) |-> (pixel_word_o[31:24] == ALPHA_BYTE), "alpha byte missing")

  // a register write starts the scale setup
  `NNSP_ASSERT(a_cfg_busy, (cfg_valid_i && cfg_ready_o) |=> busy_o, "no setup after register write")

  // no spurious result straight out of reset
  `NNSP_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !done_o, "result strobe after reset")

endmodule

bind nearest_neighbor_scale_pixel_pack_unit nnsp_checker u_nnsp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy_o       (busy_o),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .done_o       (done_o),
  .pixel_word_o (pixel_word_o),
  .status_o     (status_o)
);

[tb/nnsp_scale_checker.sv]
`timescale 1ns / 100ps

module nnsp_scale_checker
  import nnsp_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 1024,
  parameter int MAX_SRC_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_o,
  input  logic                  req_type_i,
  input  logic [11:0]           pos_x_i,
  input  logic [11:0]           pos_y_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  done_o,
  input  logic [31:0]           pixel_word_o,
  input  logic [1:0]            status_o,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  status;
  } pixel_result_t;

  // own copy of the registers and the frame
  logic [10:0] src_w_q, src_h_q;
  logic [12:0] dst_w_q, dst_h_q;
  logic [1:0]  fmt_q;
  logic [23:0] frame_q [int];
  pixel_result_t expected_pixels [$];

  // scaled lookup and packing of one fetch
  function automatic pixel_result_t scale_fetch(logic [11:0] x, logic [11:0] y);
    pixel_result_t res;
    longint unsigned sw, sh, step, col, row;
    logic [23:0] pix;
    sw = (src_w_q > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : src_w_q;
    sh = (src_h_q > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : src_h_q;
    res = '0;
    if (fmt_q > FMT_RGBA) begin
      res.status = STATUS_FORMAT;
      return res;
    end
    if (x >= dst_w_q || y >= dst_h_q || sw == 0 || sh == 0) begin
      res.status = STATUS_RANGE;
      return res;
    end
    step = (sw << FRAC_BITS) / dst_w_q;
    col  = (longint'(x) * step) >> FRAC_BITS;
    row  = (longint'(y) * sh) / dst_h_q;
    if (col > sw - 1) col = sw - 1;
    if (row > sh - 1) row = sh - 1;
    pix = frame_q.exists(int'(row * MAX_SRC_WIDTH + col)) ?
          frame_q[int'(row * MAX_SRC_WIDTH + col)] : 24'h0;
    res.status = STATUS_OK;
    if (fmt_q == FMT_BGRA)
      res.word = {ALPHA_BYTE, pix[23:16], pix[15:8], pix[7:0]};
    else
      res.word = {ALPHA_BYTE, pix[7:0], pix[15:8], pix[23:16]};
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    longint unsigned sw, sh;
    if (!rst_ni) begin
      src_w_q <= 11'd1;
      src_h_q <= 11'd1;
      dst_w_q <= 13'd1;
      dst_h_q <= 13'd1;
      fmt_q   <= FMT_BGRA;
      fail_count    <= 0;
      pending_count <= 0;
      expected_pixels.delete();
    end else begin
      // compare results against the oldest expectation
      if (done_o) begin
        if (expected_pixels.size() == 0) begin
          $error("result with no request waiting: pixel_word %h status %0d",
                 pixel_word_o, status_o);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_word_o !== want.word) begin
            $error("pixel_word expected %h actual %h", want.word, pixel_word_o);
            fail_count <= fail_count + 1;
          end
          if (status_o !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      // register writes, unknown index ignored
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SRC_WIDTH: begin
            src_w_q <= cfg_data_i[10:0];
          end
          REG_SRC_HEIGHT: begin
            src_h_q <= cfg_data_i[10:0];
          end
          REG_DST_WIDTH: begin
            dst_w_q <= cfg_data_i[12:0];
          end
          REG_DST_HEIGHT: begin
            dst_h_q <= cfg_data_i[12:0];
          end
          REG_PIXEL_FORMAT: begin
            fmt_q <= cfg_data_i[1:0];
          end
          default: begin
          end
        endcase
      end
      // accepted request: load updates the frame, fetch queues a result
      if (start_i && !busy_o) begin
        if (req_type_i == REQ_LOAD) begin
          sw = (src_w_q > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : src_w_q;
          sh = (src_h_q > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : src_h_q;
          if (pos_x_i < sw && pos_y_i < sh)
            frame_q[int'(pos_y_i) * MAX_SRC_WIDTH + int'(pos_x_i)] =
              {red_i, green_i, blue_i};
        end else begin
          expected_pixels.push_back(scale_fetch(pos_x_i, pos_y_i));
        end
      end
      pending_count <= expected_pixels.size();
    end
  end

endmodule

[tb/tb_nearest_neighbor_scale_pixel_pack_unit.sv]
`timescale 1ns / 100ps

module tb_nearest_neighbor_scale_pixel_pack_unit;
  import nnsp_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  localparam int STALL_LIMIT = 5000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic                  req_type_i = REQ_LOAD;
  logic [11:0]           pos_x_i = '0;
  logic [11:0]           pos_y_i = '0;
  logic [7:0]            red_i = '0;
  logic [7:0]            green_i = '0;
  logic [7:0]            blue_i = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  done_o;
  logic [31:0]           pixel_word_o;
  logic [1:0]            status_o;
  int                    fail_count, pending_count;

  // stimulus side mirror of the registers and of loaded pixels
  int  sw_m = 1, sh_m = 1, dw_m = 1, dh_m = 1, fmt_m = 0;
  bit  loaded_px [int];
  int  idle_pct = 0;
  int  quiet_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  nearest_neighbor_scale_pixel_pack_unit #(
    .MAX_SRC_WIDTH (MAX_W),
    .MAX_SRC_HEIGHT(MAX_H)
  ) dut (.*);

  nnsp_scale_checker #(
    .MAX_SRC_WIDTH (MAX_W),
    .MAX_SRC_HEIGHT(MAX_H)
  ) u_checker (.*);

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || (cfg_valid_i && cfg_ready_o) || done_o || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_nearest_neighbor_scale_pixel_pack_unit: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request, with random sender gaps ahead of it
  task automatic issue_request(logic kind, int x, int y, logic [23:0] rgb);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i    <= 1'b1;
    req_type_i <= kind;
    pos_x_i    <= x[11:0];
    pos_y_i    <= y[11:0];
    {red_i, green_i, blue_i} <= rgb;
    do @(posedge clk_i); while (busy_o);
    if (kind == REQ_LOAD && x < ((sw_m > MAX_W) ? MAX_W : sw_m) &&
        y < ((sh_m > MAX_H) ? MAX_H : sh_m))
      loaded_px[y * MAX_W + x] = 1'b1;
  endtask

  // write registers only once the block has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    start_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (12) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:    sw_m = value & 'h7FF;
      REG_SRC_HEIGHT:   sh_m = value & 'h7FF;
      REG_DST_WIDTH:    dw_m = value & 'h1FFF;
      REG_DST_HEIGHT:   dh_m = value & 'h1FFF;
      REG_PIXEL_FORMAT: fmt_m = value & 3;
      default: ;
    endcase
  endtask

  task automatic set_scaling(int sw, int sh, int dw, int dh, int fmt);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_PIXEL_FORMAT, fmt);
  endtask

  // source index that a fetch reads, or -1 when it reads nothing
  function automatic int source_index(int x, int y);
    longint sw, sh, step, col, row;
    sw = (sw_m > MAX_W) ? MAX_W : sw_m;
    sh = (sh_m > MAX_H) ? MAX_H : sh_m;
    if (fmt_m > 1 || x >= dw_m || y >= dh_m || sw == 0 || sh == 0) return -1;
    step = (sw << FRAC_BITS) / dw_m;
    col  = (x * step) >> FRAC_BITS;
    row  = (y * sh) / dh_m;
    if (col > sw - 1) col = sw - 1;
    if (row > sh - 1) row = sh - 1;
    return int'(row * MAX_W + col);
  endfunction

  // fetch, loading the source pixel first when it was never written
  task automatic fetch_pixel(int x, int y);
    int idx;
    idx = source_index(x, y);
    if (idx >= 0 && !loaded_px.exists(idx))
      issue_request(REQ_LOAD, idx % MAX_W, idx / MAX_W, 24'($urandom));
    issue_request(REQ_FETCH, x, y, 24'($urandom));
  endtask

  function automatic int pick_coord(int bound);
    case ($urandom_range(9))
      0: return $urandom_range(4095);
      1: return (bound > 4095) ? 4095 : bound;
      default: return (bound == 0) ? 0 : $urandom_range((bound > 4096) ? 4095 : bound - 1);
    endcase
  endfunction

  task automatic random_phase(int pct, int count);
    int sw, sh;
    idle_pct = pct;
    sw = (sw_m > MAX_W) ? MAX_W : sw_m;
    sh = (sh_m > MAX_H) ? MAX_H : sh_m;
    repeat (count) begin
      if ($urandom_range(99) < 40)
        issue_request(REQ_LOAD, pick_coord(sw), pick_coord(sh), 24'($urandom));
      else
        fetch_pixel(pick_coord(dw_m), pick_coord(dh_m));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults, color extremes, ignored loads, range edges
    issue_request(REQ_LOAD, 0, 0, 24'hFFFFFF);
    fetch_pixel(0, 0);
    issue_request(REQ_LOAD, 0, 0, 24'h000000);
    fetch_pixel(0, 0);
    issue_request(REQ_LOAD, 0, 0, 24'h12AB7F);
    issue_request(REQ_LOAD, 1, 0, 24'hFFFFFF);
    issue_request(REQ_LOAD, 4095, 4095, 24'hFFFFFF);
    fetch_pixel(0, 0);
    fetch_pixel(1, 0);
    fetch_pixel(0, 1);
    fetch_pixel(4095, 4095);
    write_reg(REG_PIXEL_FORMAT, FMT_RGBA);
    fetch_pixel(0, 0);
    write_reg(REG_PIXEL_FORMAT, 2);
    fetch_pixel(0, 0);
    fetch_pixel(4095, 4095);
    write_reg(REG_PIXEL_FORMAT, 3);
    fetch_pixel(0, 0);
    // unknown register indexes are ignored
    write_reg(3'd5, 'h1FFF);
    write_reg(3'd6, 0);
    write_reg(3'd7, 'h0AAA);

    set_scaling(8, 6, 20, 13, FMT_BGRA);
    random_phase(0, 200);
    set_scaling(1024, 1024, 4096, 4096, FMT_RGBA);
    random_phase(85, 150);
    set_scaling('h1FFF, 5, 3, 'h1FFF, FMT_BGRA);
    random_phase(30, 150);
    set_scaling(16, 16, 8, 8, FMT_RGBA);
    random_phase(0, 150);
    set_scaling(0, 7, 10, 10, FMT_BGRA);
    random_phase(85, 80);
    set_scaling(5, 5, 0, 9, FMT_BGRA);
    random_phase(0, 60);
    set_scaling(33, 17, 100, 50, 2);
    random_phase(30, 100);
    set_scaling(7, 3, 4096, 1, FMT_BGRA);
    random_phase(0, 200);

    start_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb_nearest_neighbor_scale_pixel_pack_unit: done, clean");
    else
      $display("tb_nearest_neighbor_scale_pixel_pack_unit: done, errors");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/nnsp_pkg.sv
src/nnsp_div.sv
src/nnsp_frame_mem.sv
src/nearest_neighbor_scale_pixel_pack_unit.sv
src/nnsp_checker.sv
tb/nnsp_scale_checker.sv
tb/tb_nearest_neighbor_scale_pixel_pack_unit.sv
